>>> rtl/afv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afv_pkg
// Shared types, register map and constants of the fade / volume output core.
// ----------------------------------------------------------------------------
package afv_pkg;

	localparam int unsigned PADDR_W         = 5;
	localparam int unsigned AFV_QUEUE_DEPTH = 2;

	localparam logic [31:0] NONE_POS = 32'hFFFF_FFFF;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_SONG_VOLUME   = 3'd0;
	localparam logic [2:0] REG_FADE_LENGTH   = 3'd1;
	localparam logic [2:0] REG_END_SILENCE   = 3'd2;
	localparam logic [2:0] REG_CHAN_INVERT   = 3'd3;
	localparam logic [2:0] REG_OUTPUT_FORMAT = 3'd4;
	localparam logic [2:0] REG_LOOP_LIMIT    = 3'd5;

	// reset values
	localparam logic [30:0] RST_SONG_VOLUME = 31'h0001_0000;
	localparam logic [1:0]  RST_FORMAT      = 2'd1;
	localparam logic [31:0] RST_LOOP_LIMIT  = 32'd2;

	// output formats
	localparam logic [1:0] FMT_U8  = 2'd0;
	localparam logic [1:0] FMT_S16 = 2'd1;
	localparam logic [1:0] FMT_S24 = 2'd2;
	localparam logic [1:0] FMT_S32 = 2'd3;

	typedef enum logic [2:0] {
		MODE_SAMPLE  = 3'd0,
		MODE_FADE    = 3'd1,
		MODE_LOOP    = 3'd2,
		MODE_END     = 3'd3,
		MODE_SEEK    = 3'd4,
		MODE_RESTART = 3'd5
	} mode_t;

	// how the back end gets its volume
	typedef enum logic [1:0] {
		VOL_FULL = 2'd0,
		VOL_ZERO = 2'd1,
		VOL_FADE = 2'd2
	} vsel_t;

	typedef struct packed {
		logic [30:0] song_volume;
		logic [31:0] fade_length;
		logic [31:0] end_silence_length;
		logic [1:0]  channel_invert;
		logic [1:0]  output_format;
		logic [31:0] loop_limit;
	} cfg_t;

	// one classified request handed from front to back
	typedef struct packed {
		logic        has_sample;
		vsel_t       vsel;
		logic [31:0] elapsed;
		logic [31:0] left;
		logic [31:0] right;
		logic        ended;
		logic        finished;
		logic        evt;
		logic        fading;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/afv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afv_front
// Takes requests, keeps fade / silence positions and flags, classifies each
// request and pushes it into the queue toward the back end.
// ----------------------------------------------------------------------------
module afv_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire afv_pkg::cfg_t   cfg,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [2:0]      mode,
	input  wire logic [31:0]     position,
	input  wire logic [31:0]     left_sample,
	input  wire logic [31:0]     right_sample,
	input  wire logic [31:0]     loop_number,
	output logic                 push,
	output afv_pkg::entry_t      push_data,
	input  wire logic            q_full
);
	import afv_pkg::*;

	logic        busy_q;
	mode_t       mode_q;
	logic [31:0] pos_q, loops_q, left_q, right_q;
	logic [31:0] fs_q, ss_q;
	logic        ended_q, fin_q;

	logic [31:0] fs_n, ss_n;
	logic        ended_n, fin_n, evt;
	logic        pos_none, fs_none, ss_none, in_fade, fade_over, set_ended, ss_take;
	logic        sil_old;
	logic [31:0] el, sil_el;
	vsel_t       vsel;

	assign in_stall = busy_q & q_full;
	assign push     = busy_q & ~q_full;

	assign pos_none  = (pos_q == NONE_POS);
	assign fs_none   = (fs_q == NONE_POS);
	assign ss_none   = (ss_q == NONE_POS);
	assign el        = pos_q - fs_q;
	assign sil_el    = pos_q - ss_q;
	assign in_fade   = ~fs_none & ~pos_none & (pos_q >= fs_q);
	assign fade_over = in_fade & (el >= cfg.fade_length);
	assign set_ended = fade_over & ~ended_q;
	// silence start taken at this very sample, so elapsed silence is zero
	assign ss_take   = set_ended & ss_none;
	assign sil_old   = ~ss_none & ~pos_none & (pos_q >= ss_q)
	                 & (sil_el >= cfg.end_silence_length);

	always_comb begin
		fs_n    = fs_q;
		ss_n    = ss_q;
		ended_n = ended_q;
		fin_n   = fin_q;
		evt     = 1'b0;
		vsel    = VOL_FULL;
		case (mode_q)
			MODE_SAMPLE: begin
				if (ss_take) begin
					ss_n = pos_q;
				end
				ended_n = ended_q | set_ended;
				evt     = ~fin_q & (ss_take ? (cfg.end_silence_length == 32'd0) : sil_old);
				fin_n   = fin_q | evt;
				if (!in_fade) begin
					vsel = VOL_FULL;
				end else if (fade_over) begin
					vsel = VOL_ZERO;
				end else begin
					vsel = VOL_FADE;
				end
			end
			MODE_FADE: begin
				if (fs_none) fs_n = pos_q;
			end
			MODE_LOOP: begin
				if (fs_none && cfg.loop_limit != 32'd0 && loops_q >= cfg.loop_limit) begin
					fs_n = pos_q;
				end
			end
			MODE_END: begin
				ended_n = 1'b1;
				ss_n    = pos_q;
			end
			MODE_SEEK: begin
				if (pos_q < fs_q) fs_n = NONE_POS;
				if (pos_q < ss_q) ss_n = NONE_POS;
				ended_n = 1'b0;
				fin_n   = 1'b0;
			end
			MODE_RESTART: begin
				fs_n    = NONE_POS;
				ss_n    = NONE_POS;
				ended_n = 1'b0;
				fin_n   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		push_data.has_sample = (mode_q == MODE_SAMPLE) & ~evt;
		push_data.vsel       = vsel;
		push_data.elapsed    = el;
		push_data.left       = left_q;
		push_data.right      = right_q;
		push_data.ended      = ended_n;
		push_data.finished   = fin_n;
		push_data.evt        = evt;
		push_data.fading     = (fs_n != NONE_POS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			fs_q    <= NONE_POS;
			ss_q    <= NONE_POS;
			ended_q <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (push) begin
				fs_q    <= fs_n;
				ss_q    <= ss_n;
				ended_q <= ended_n;
				fin_q   <= fin_n;
			end
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q  <= mode_t'(mode);
			pos_q   <= position;
			loops_q <= loop_number;
			left_q  <= left_sample;
			right_q <= right_sample;
		end
	end

endmodule
`default_nettype wire

>>> rtl/afv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afv_queue
// Small register queue between front and back ends (depth 2 or more).
// ----------------------------------------------------------------------------
module afv_queue #(
	parameter int unsigned DEPTH = afv_pkg::AFV_QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire afv_pkg::entry_t push_data,
	output logic                 full,
	input  wire logic            pop,
	output afv_pkg::entry_t      pop_data,
	output logic                 not_empty
);
	import afv_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> not_empty)
		else $error("queue pop while empty");
`endif

endmodule
`default_nettype wire

>>> rtl/afv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// afv_back
// Computes the fade gain with a serial divider, scales the samples through a
// shared multiplier, inverts and packs them into the output register.
// ----------------------------------------------------------------------------
module afv_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire afv_pkg::cfg_t   cfg,
	input  wire logic            q_not_empty,
	input  wire afv_pkg::entry_t q_data,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 sample_valid,
	output logic [31:0]          left_word,
	output logic [31:0]          right_word,
	output logic                 end_reached,
	output logic                 finished,
	output logic                 end_event,
	output logic                 fading
);
	import afv_pkg::*;

	typedef enum logic [3:0] {
		B_IDLE, B_DIV, B_SQ, B_PLO, B_PHI, B_SUM, B_ML, B_MR, B_NR, B_OUT
	} bstate_t;

	localparam logic [3:0] DIV_LAST = 4'd15;

	bstate_t            state_q;
	entry_t             ent_q;
	logic [3:0]         cnt_q;
	logic [31:0]        rem_q;
	logic [15:0]        quo_q;
	logic [32:0]        sq_q;
	logic [46:0]        plo_q;
	logic [47:0]        phi_q;
	logic [30:0]        vol_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] val_l_q, val_r_q;

	logic        out_valid_q, smp_valid_q, evt_q, ended_q, fin_q, fading_q;
	logic [31:0] lw_q, rw_q;

	logic [32:0]        rem_sh, rem_sub;
	logic               qbit;
	logic [16:0]        fv;
	logic [33:0]        sq_full;
	logic [46:0]        plo;
	logic [47:0]        phi;
	logic [63:0]        gain_sum;
	logic signed [31:0] mul_a, vol_s;
	logic signed [63:0] mul_p;
	logic               out_write;

	function automatic logic signed [47:0] scale(input logic signed [63:0] p, input logic inv);
		logic signed [47:0] s;
		s = signed'(p[63:16]);
		return inv ? -s : s;
	endfunction

	function automatic logic [31:0] pack(input logic signed [47:0] v, input logic [1:0] fmt);
		logic signed [47:0] t;
		logic [31:0]        w;
		t = v;
		w = '0;
		case (fmt)
			FMT_U8: begin
				t = v >>> 16;
				if (t < -48'sd128) t = -48'sd128;
				else if (t > 48'sd127) t = 48'sd127;
				w = {24'b0, ~t[7], t[6:0]};
			end
			FMT_S16: begin
				t = v >>> 8;
				if (t < -48'sd32768) t = -48'sd32768;
				else if (t > 48'sd32767) t = 48'sd32767;
				w = {16'b0, t[15:0]};
			end
			FMT_S24: begin
				if (t < -48'sd8388608) t = -48'sd8388608;
				else if (t > 48'sd8388607) t = 48'sd8388607;
				w = {8'b0, t[23:0]};
			end
			default: begin
				if (t < -48'sd8388608) t = -48'sd8388608;
				else if (t > 48'sd8388607) t = 48'sd8388607;
				w = {t[23:0], 8'b0};
			end
		endcase
		return w;
	endfunction

	// restoring divide step: remainder stays below fade_length
	assign rem_sh  = {rem_q, 1'b0};
	assign qbit    = (rem_sh >= {1'b0, cfg.fade_length});
	assign rem_sub = rem_sh - {1'b0, cfg.fade_length};

	assign fv       = 17'h10000 - {1'b0, quo_q};
	assign sq_full  = fv * fv;
	assign plo      = sq_q[15:0] * cfg.song_volume;
	assign phi      = sq_q[32:16] * cfg.song_volume;
	assign gain_sum = {phi_q, 16'b0} + {17'b0, plo_q};

	assign mul_a = signed'((state_q == B_ML) ? ent_q.left : ent_q.right);
	assign vol_s = signed'({1'b0, vol_q});
	assign mul_p = mul_a * vol_s;

	assign pop       = (state_q == B_IDLE) & q_not_empty;
	assign out_write = (state_q == B_OUT) & (~out_valid_q | ~out_stall);

	assign out_valid    = out_valid_q;
	assign sample_valid = smp_valid_q;
	assign left_word    = lw_q;
	assign right_word   = rw_q;
	assign end_reached  = ended_q;
	assign finished     = fin_q;
	assign end_event    = evt_q;
	assign fading       = fading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_write) begin
				out_valid_q <= 1'b1;
				smp_valid_q <= ent_q.has_sample;
				lw_q        <= ent_q.has_sample ? pack(val_l_q, cfg.output_format) : 32'd0;
				rw_q        <= ent_q.has_sample ? pack(val_r_q, cfg.output_format) : 32'd0;
				ended_q     <= ent_q.ended;
				fin_q       <= ent_q.finished;
				evt_q       <= ent_q.evt;
				fading_q    <= ent_q.fading;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_not_empty) begin
						ent_q <= q_data;
						rem_q <= q_data.elapsed;
						quo_q <= '0;
						cnt_q <= '0;
						vol_q <= (q_data.vsel == VOL_FULL) ? cfg.song_volume : 31'd0;
						if (!q_data.has_sample) begin
							state_q <= B_OUT;
						end else if (q_data.vsel == VOL_FADE) begin
							state_q <= B_DIV;
						end else begin
							state_q <= B_ML;
						end
					end
				end
				B_DIV: begin
					rem_q <= qbit ? rem_sub[31:0] : rem_sh[31:0];
					quo_q <= {quo_q[14:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) state_q <= B_SQ;
				end
				B_SQ: begin
					sq_q    <= sq_full[32:0];
					state_q <= B_PLO;
				end
				B_PLO: begin
					plo_q   <= plo;
					state_q <= B_PHI;
				end
				B_PHI: begin
					phi_q   <= phi;
					state_q <= B_SUM;
				end
				B_SUM: begin
					vol_q   <= gain_sum[62:32];
					state_q <= B_ML;
				end
				B_ML: begin
					prod_q  <= mul_p;
					state_q <= B_MR;
				end
				B_MR: begin
					val_l_q <= scale(prod_q, cfg.channel_invert[0]);
					prod_q  <= mul_p;
					state_q <= B_NR;
				end
				B_NR: begin
					val_r_q <= scale(prod_q, cfg.channel_invert[1]);
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_write) state_q <= B_IDLE;
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_empty_words: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !smp_valid_q |-> (lw_q == 32'd0 && rw_q == 32'd0))
		else $error("result without sample carries nonzero words");
	a_event_finished: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evt_q |-> fin_q && !smp_valid_q)
		else $error("end event without finished flag or with a sample");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_DIV && cnt_q == DIV_LAST |=> state_q == B_SQ)
		else $error("divider did not hand over after last step");
`endif

endmodule
`default_nettype wire

>>> rtl/audio_fade_volume_output_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_fade_volume_output_core
// Song output stage with fade-out, end silence and packed sample output.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  in       in_valid / in_stall     mode, position, left/right_sample, loop_number
//  out      out_valid / out_stall   sample_valid, left/right_word, flags
//  cfg      psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
//  front end takes a request per cycle into a queue while it is not full; the back
//  end sends an event straight out, a plain sample through the shared multiplier
//  and a fade sample first through the 16-step serial divider and the gain states
//  reset clears positions to none, flags and the queue; no clearing pass
//  a stalled output holds its result while up to QUEUE_DEPTH + 2 more
//  requests are taken
// ----------------------------------------------------------------------------
module audio_fade_volume_output_core #(
	parameter int unsigned QUEUE_DEPTH = afv_pkg::AFV_QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [2:0]                  mode,
	input  wire logic [31:0]                 position,
	input  wire logic [31:0]                 left_sample,
	input  wire logic [31:0]                 right_sample,
	input  wire logic [31:0]                 loop_number,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             sample_valid,
	output logic [31:0]                      left_word,
	output logic [31:0]                      right_word,
	output logic                             end_reached,
	output logic                             finished,
	output logic                             end_event,
	output logic                             fading,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [afv_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import afv_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       cfg_wr;

	logic   push, q_full, pop, q_not_empty;
	entry_t push_data, pop_data;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.song_volume        <= RST_SONG_VOLUME;
			cfg_q.fade_length        <= '0;
			cfg_q.end_silence_length <= '0;
			cfg_q.channel_invert     <= '0;
			cfg_q.output_format      <= RST_FORMAT;
			cfg_q.loop_limit         <= RST_LOOP_LIMIT;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SONG_VOLUME:   cfg_q.song_volume        <= pwdata[30:0];
				REG_FADE_LENGTH:   cfg_q.fade_length        <= pwdata;
				REG_END_SILENCE:   cfg_q.end_silence_length <= pwdata;
				REG_CHAN_INVERT:   cfg_q.channel_invert     <= pwdata[1:0];
				REG_OUTPUT_FORMAT: cfg_q.output_format      <= pwdata[1:0];
				REG_LOOP_LIMIT:    cfg_q.loop_limit         <= pwdata;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SONG_VOLUME:   prdata = {1'b0, cfg_q.song_volume};
			REG_FADE_LENGTH:   prdata = cfg_q.fade_length;
			REG_END_SILENCE:   prdata = cfg_q.end_silence_length;
			REG_CHAN_INVERT:   prdata = {30'b0, cfg_q.channel_invert};
			REG_OUTPUT_FORMAT: prdata = {30'b0, cfg_q.output_format};
			REG_LOOP_LIMIT:    prdata = cfg_q.loop_limit;
			default:           prdata = 32'd0;
		endcase
	end

	afv_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.position     (position),
		.left_sample  (left_sample),
		.right_sample (right_sample),
		.loop_number  (loop_number),
		.push         (push),
		.push_data    (push_data),
		.q_full       (q_full)
	);

	afv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	afv_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_not_empty  (q_not_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_valid (sample_valid),
		.left_word    (left_word),
		.right_word   (right_word),
		.end_reached  (end_reached),
		.finished     (finished),
		.end_event    (end_event),
		.fading       (fading)
	);

endmodule
`default_nettype wire
